[rtl/bcc_pkg.sv]
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the book cipher codec.
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int BCC_MAX_CODES  = 1024;
    localparam int BCC_LIST_DEPTH = 64;
    localparam int ALPHABET_SIZE  = 26;
    localparam int RAND_W         = 15;
    localparam int CODE_W         = 10;
    localparam int CHAR_W         = 8;
    localparam int LETTER_W       = 5;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_CLOSE  = 2'd1,
        ACT_ENCODE = 2'd2,
        ACT_DECODE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SKIP       = 3'd1,
        ST_STORE_FULL = 3'd2,
        ST_LIST_FULL  = 3'd3,
        ST_BAD_CODE   = 3'd4,
        ST_NO_CODE    = 3'd5
    } status_t;

    typedef struct packed {
        action_t               action;
        logic                  is_letter;
        logic [LETTER_W-1:0]   letter;
        logic [CODE_W-1:0]     code_in;
        logic [RAND_W-1:0]     random_value;
    } item_t;

endpackage

[rtl/bcc_front.sv]
// ----------------------------------------------------------------------------
// bcc_front
// Accepts commands, folds case and classifies letters, feeds the queue.
// ----------------------------------------------------------------------------
module bcc_front
    import bcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        action,
    input  logic [CHAR_W-1:0] char_in,
    input  logic [CODE_W-1:0] code_in,
    input  logic [RAND_W-1:0] random_value,
    input  logic              queue_full,
    output logic              push,
    output item_t             push_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    item_t classified;
    logic  accept;

    always_comb
    begin
        classified              = '0;
        classified.action       = action_t'(action);
        classified.code_in      = code_in;
        classified.random_value = random_value;
        if (char_in inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})
        begin
            classified.is_letter = 1'b1;
            classified.letter    = LETTER_W'(char_in - CHAR_UPPER_A);
        end
        else if (char_in inside {[CHAR_LOWER_A:CHAR_LOWER_Z]})
        begin
            classified.is_letter = 1'b1;
            classified.letter    = LETTER_W'(char_in - CHAR_LOWER_A);
        end
    end

    assign busy      = valid_reg && queue_full;
    assign accept    = start && !busy;
    assign push      = valid_reg && !queue_full;
    assign push_item = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            item_next  = classified;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

[rtl/bcc_fifo.sv]
// ----------------------------------------------------------------------------
// bcc_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module bcc_fifo
    import bcc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  full,
    output logic  empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/bcc_mod.sv]
// ----------------------------------------------------------------------------
// bcc_mod
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module bcc_mod
    import bcc_pkg::*;
#(
    parameter int LEN_W = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAND_W-1:0] dividend,
    input  logic [LEN_W-1:0]  divisor,
    output logic              done,
    output logic [LEN_W-1:0]  remainder
);

    localparam int STEP_W = $clog2(RAND_W);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [RAND_W-1:0] dvd_reg;
    logic [RAND_W-1:0] dvd_next;
    logic [LEN_W-1:0]  div_reg;
    logic [LEN_W-1:0]  div_next;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W-1:0]  rem_next;
    logic [LEN_W:0]    rem_shift;
    logic [LEN_W:0]    rem_sub;

    assign rem_shift = {rem_reg, dvd_reg[RAND_W-1]};
    assign rem_sub   = rem_shift - {1'b0, div_reg};
    assign done      = done_reg;
    assign remainder = rem_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next  = {dvd_reg[RAND_W-2:0], 1'b0};
            rem_next  = (rem_shift >= {1'b0, div_reg}) ? rem_sub[LEN_W-1:0]
                                                      : rem_shift[LEN_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(RAND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

endmodule

[rtl/bcc_back.sv]
// ----------------------------------------------------------------------------
// bcc_back
// Executes queued commands against the code store and the letter lists.
// ----------------------------------------------------------------------------
module bcc_back
    import bcc_pkg::*;
#(
    parameter int MAX_CODES  = BCC_MAX_CODES,
    parameter int LIST_DEPTH = BCC_LIST_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              queue_empty,
    input  item_t             queue_head,
    output logic              pop,
    output logic              done,
    output logic [2:0]        status,
    output logic [CODE_W-1:0] code_out,
    output logic [CHAR_W-1:0] letter_out
);

    localparam int CW     = $clog2(MAX_CODES + 1);
    localparam int PW     = $clog2(MAX_CODES);
    localparam int LW     = $clog2(LIST_DEPTH + 1);
    localparam int LDEPTH = ALPHABET_SIZE * LIST_DEPTH;
    localparam int AW     = $clog2(LDEPTH);
    localparam int CMPW   = (CW > CODE_W) ? CW : CODE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CLOSE,
        S_MOD,
        S_ENC_READ,
        S_ENC_OUT,
        S_DEC_OUT
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    item_t                item_reg;
    item_t                item_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [LW-1:0]        len_reg [ALPHABET_SIZE];
    logic [LW-1:0]        len_next [ALPHABET_SIZE];
    logic [LETTER_W-1:0]  k_reg;
    logic [LETTER_W-1:0]  k_next;
    status_t              acc_reg;
    status_t              acc_next;
    logic [AW-1:0]        addr_reg;
    logic [AW-1:0]        addr_next;
    logic                 done_reg;
    logic                 done_next;
    status_t              status_reg;
    status_t              status_next;
    logic [CODE_W-1:0]    code_reg;
    logic [CODE_W-1:0]    code_next;
    logic [CHAR_W-1:0]    letter_reg;
    logic [CHAR_W-1:0]    letter_next;

    logic [LETTER_W-1:0]  store_mem [MAX_CODES];
    logic [PW-1:0]        list_mem [LDEPTH];
    logic                 store_we;
    logic [PW-1:0]        store_waddr;
    logic [LETTER_W-1:0]  store_wdata;
    logic [PW-1:0]        store_raddr;
    logic [LETTER_W-1:0]  store_rd_reg;
    logic                 list_we;
    logic [AW-1:0]        list_waddr;
    logic [PW-1:0]        list_wdata;
    logic [AW-1:0]        list_raddr;
    logic [PW-1:0]        list_rd_reg;

    logic                 mod_start;
    logic                 mod_done;
    logic [LW-1:0]        mod_rem;

    logic [LW-1:0]        cur_len;
    logic [LW-1:0]        k_len;
    logic                 store_full;
    logic [PW-1:0]        pos;
    logic                 bad_code;
    logic                 full_now;

    assign cur_len    = len_reg[item_reg.letter];
    assign k_len      = len_reg[k_reg];
    assign store_full = (count_reg >= CW'(MAX_CODES));
    assign pos        = count_reg[PW-1:0];
    assign bad_code   = (CMPW'(item_reg.code_in) >= CMPW'(count_reg));

    bcc_mod #(
        .LEN_W (LW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (item_reg.random_value),
        .divisor   (cur_len),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        k_next      = k_reg;
        acc_next    = acc_reg;
        addr_next   = addr_reg;
        done_next   = 1'b0;
        status_next = ST_OK;
        code_next   = '0;
        letter_next = '0;
        pop         = 1'b0;
        mod_start   = 1'b0;
        store_we    = 1'b0;
        store_waddr = pos;
        store_wdata = '0;
        store_raddr = '0;
        list_we     = 1'b0;
        list_waddr  = '0;
        list_wdata  = pos;
        list_raddr  = addr_reg;
        full_now    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    item_next  = queue_head;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (item_reg.action)
                    ACT_LOAD:
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                        if (!item_reg.is_letter)
                        begin
                            status_next = ST_SKIP;
                        end
                        else if (store_full)
                        begin
                            status_next = ST_STORE_FULL;
                        end
                        else
                        begin
                            store_we    = 1'b1;
                            store_wdata = item_reg.letter;
                            code_next   = CODE_W'(pos);
                            count_next  = count_reg + 1'b1;
                            if (cur_len < LW'(LIST_DEPTH))
                            begin
                                list_we    = 1'b1;
                                list_waddr = AW'(item_reg.letter) * AW'(LIST_DEPTH)
                                           + AW'(cur_len);
                                len_next[item_reg.letter] = cur_len + 1'b1;
                            end
                            else
                            begin
                                status_next = ST_LIST_FULL;
                            end
                        end
                    end
                    ACT_CLOSE:
                    begin
                        k_next     = '0;
                        acc_next   = ST_OK;
                        state_next = S_CLOSE;
                    end
                    ACT_ENCODE:
                    begin
                        if (!item_reg.is_letter)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_SKIP;
                            state_next  = S_IDLE;
                        end
                        else if (cur_len == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NO_CODE;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            mod_start  = 1'b1;
                            state_next = S_MOD;
                        end
                    end
                    ACT_DECODE:
                    begin
                        if (bad_code)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_BAD_CODE;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            store_raddr = PW'(item_reg.code_in);
                            state_next  = S_DEC_OUT;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_CLOSE:
            begin
                if (k_len == '0)
                begin
                    if (store_full)
                    begin
                        full_now = 1'b1;
                    end
                    else
                    begin
                        store_we       = 1'b1;
                        store_wdata    = k_reg;
                        list_we        = 1'b1;
                        list_waddr     = AW'(k_reg) * AW'(LIST_DEPTH);
                        len_next[k_reg] = LW'(1);
                        count_next     = count_reg + 1'b1;
                    end
                end
                if (k_reg == LETTER_W'(ALPHABET_SIZE - 1))
                begin
                    done_next   = 1'b1;
                    status_next = (full_now || acc_reg == ST_STORE_FULL) ? ST_STORE_FULL
                                                                          : ST_OK;
                    state_next  = S_IDLE;
                end
                else
                begin
                    acc_next = full_now ? ST_STORE_FULL : acc_reg;
                    k_next   = k_reg + 1'b1;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    addr_next  = AW'(item_reg.letter) * AW'(LIST_DEPTH) + AW'(mod_rem);
                    state_next = S_ENC_READ;
                end
            end
            S_ENC_READ:
            begin
                state_next = S_ENC_OUT;
            end
            S_ENC_OUT:
            begin
                done_next  = 1'b1;
                code_next  = CODE_W'(list_rd_reg);
                state_next = S_IDLE;
            end
            S_DEC_OUT:
            begin
                done_next   = 1'b1;
                letter_next = CHAR_LOWER_A + CHAR_W'(store_rd_reg);
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            k_reg     <= '0;
            acc_reg   <= ST_OK;
            done_reg  <= 1'b0;
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            acc_reg   <= acc_next;
            done_reg  <= done_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        addr_reg   <= addr_next;
        status_reg <= status_next;
        code_reg   <= code_next;
        letter_reg <= letter_next;
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_waddr] <= store_wdata;
        end
        store_rd_reg <= store_mem[store_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[list_waddr] <= list_wdata;
        end
        list_rd_reg <= list_mem[list_raddr];
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign code_out   = code_reg;
    assign letter_out = letter_reg;

endmodule

[rtl/book_cipher_codec.sv]
// ----------------------------------------------------------------------------
// book_cipher_codec
// Homophonic book cipher: key load, key close, encode and decode commands.
// ----------------------------------------------------------------------------
// latency from accepted start to done spans the front register, the queue
// and the back-end states of the command; the back end runs one command at
// a time, encode waits on the 15-step remainder unit, close on the letter walk
// busy rises only when the front register and the 2-entry queue are both full
// results are one-cycle done pulses, the receiver cannot stall them
// reset clears list lengths, code count and queue; no clearing pass
module book_cipher_codec
    import bcc_pkg::*;
#(
    parameter int MAX_CODES  = BCC_MAX_CODES,
    parameter int LIST_DEPTH = BCC_LIST_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        action,
    input  logic [CHAR_W-1:0] char_in,
    input  logic [CODE_W-1:0] code_in,
    input  logic [RAND_W-1:0] random_value,
    output logic              done,
    output logic [2:0]        status,
    output logic [CODE_W-1:0] code_out,
    output logic [CHAR_W-1:0] letter_out
);

    logic  push;
    item_t push_item;
    logic  pop;
    item_t head;
    logic  full;
    logic  empty;

    bcc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .char_in      (char_in),
        .code_in      (code_in),
        .random_value (random_value),
        .queue_full   (full),
        .push         (push),
        .push_item    (push_item)
    );

    bcc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    bcc_back #(
        .MAX_CODES  (MAX_CODES),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (empty),
        .queue_head  (head),
        .pop         (pop),
        .done        (done),
        .status      (status),
        .code_out    (code_out),
        .letter_out  (letter_out)
    );

endmodule

[rtl/bcc_checker.sv]
// ----------------------------------------------------------------------------
// bcc_checker
// Port-level checks on the result transfers of the codec.
// ----------------------------------------------------------------------------
module bcc_checker
    import bcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              done,
    input  logic [2:0]        status,
    input  logic [CODE_W-1:0] code_out,
    input  logic [CHAR_W-1:0] letter_out
);

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= ST_NO_CODE))
        else $error("status code out of range");

    a_code_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK && status != ST_LIST_FULL) |-> (code_out == '0))
        else $error("code_out set on a failed transfer");

    a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && letter_out != '0) |->
            (status == ST_OK && letter_out >= CHAR_LOWER_A && letter_out <= CHAR_LOWER_Z))
        else $error("letter_out not a lowercase letter");

    a_one_payload: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (code_out == '0 || letter_out == '0))
        else $error("code and letter both set");

endmodule

bind book_cipher_codec bcc_checker u_bcc_checker (.*);

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for book_cipher_codec. Key characters, key close,
// encode and decode commands go through the start/busy handshake with random
// gaps. A cipher model in the bench tracks the code store and the per-letter
// code lists. Each done pulse is compared with the oldest predicted outcome.
// The run fills the store so that a key close runs out of room partway.
// ----------------------------------------------------------------------------
module testbench;
    import bcc_pkg::*;

    typedef struct {
        status_t           st;
        logic [CODE_W-1:0] code;
        logic [CHAR_W-1:0] letter;
    } cipher_outcome_t;

    // letters q..y stay without codes until the key is closed
    localparam int HELD_FIRST    = 16;
    localparam int HELD_LAST     = 24;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int SETTLE_CYCLES = 40;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              start        = 1'b0;
    logic [1:0]        action       = 2'd0;
    logic [CHAR_W-1:0] char_in      = '0;
    logic [CODE_W-1:0] code_in      = '0;
    logic [RAND_W-1:0] random_value = '0;
    logic              busy;
    logic              done;
    logic [2:0]        status;
    logic [CODE_W-1:0] code_out;
    logic [CHAR_W-1:0] letter_out;

    logic [LETTER_W-1:0] letter_at_code [BCC_MAX_CODES];
    logic [CODE_W-1:0]   codes_of_letter [ALPHABET_SIZE][BCC_LIST_DEPTH];
    int unsigned         codes_per_letter [ALPHABET_SIZE] = '{default: 0};
    int unsigned         codes_issued = 0;

    cipher_outcome_t outcomes_due[$];
    int              mismatches = 0;
    int              items_sent = 0;
    bit              no_gap     = 1'b0;

    book_cipher_codec uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .char_in      (char_in),
        .code_in      (code_in),
        .random_value (random_value),
        .done         (done),
        .status       (status),
        .code_out     (code_out),
        .letter_out   (letter_out)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [CHAR_W-1:0] rand_byte();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CODE_W-1:0] rand_code();
        return CODE_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic [RAND_W-1:0] rand_value();
        return RAND_W'($urandom_range(0, 32767));
    endfunction

    function automatic int letter_of(logic [CHAR_W-1:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            return int'(c - CHAR_UPPER_A);
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            return int'(c - CHAR_LOWER_A);
        return -1;
    endfunction

    function automatic status_t issue_code(int li);
        status_t st;
        st = ST_OK;
        letter_at_code[codes_issued] = LETTER_W'(li);
        if (codes_per_letter[li] < BCC_LIST_DEPTH)
        begin
            codes_of_letter[li][codes_per_letter[li]] = CODE_W'(codes_issued);
            codes_per_letter[li]++;
        end
        else
            st = ST_LIST_FULL;
        codes_issued++;
        return st;
    endfunction

    function automatic cipher_outcome_t cipher_outcome(action_t act, logic [CHAR_W-1:0] ch,
            logic [CODE_W-1:0] code, logic [RAND_W-1:0] rnd);
        cipher_outcome_t r;
        int              li;
        r.st     = ST_OK;
        r.code   = '0;
        r.letter = '0;
        li       = letter_of(ch);
        case (act)
            ACT_LOAD:
            begin
                if (li < 0)
                    r.st = ST_SKIP;
                else if (codes_issued >= BCC_MAX_CODES)
                    r.st = ST_STORE_FULL;
                else
                begin
                    r.code = CODE_W'(codes_issued);
                    r.st   = issue_code(li);
                end
            end
            ACT_CLOSE:
            begin
                for (int k = 0; k < ALPHABET_SIZE; k++)
                begin
                    if (codes_per_letter[k] == 0)
                    begin
                        if (codes_issued >= BCC_MAX_CODES)
                            r.st = ST_STORE_FULL;
                        else
                            void'(issue_code(k));
                    end
                end
            end
            ACT_ENCODE:
            begin
                if (li < 0)
                    r.st = ST_SKIP;
                else if (codes_per_letter[li] == 0)
                    r.st = ST_NO_CODE;
                else
                    r.code = codes_of_letter[li][int'(rnd) % codes_per_letter[li]];
            end
            default:
            begin
                if (code >= codes_issued)
                    r.st = ST_BAD_CODE;
                else
                    r.letter = CHAR_LOWER_A + letter_at_code[code];
            end
        endcase
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] cased_letter(int li);
        if ($urandom_range(0, 1) == 1)
            return CHAR_UPPER_A + CHAR_W'(li);
        return CHAR_LOWER_A + CHAR_W'(li);
    endfunction

    // key letters avoid q..y, with a heavy lean on e so its list overflows
    function automatic logic [CHAR_W-1:0] key_letter_byte();
        int li;
        li = $urandom_range(0, 16);
        if ($urandom_range(0, 9) < 3)
            li = 4;
        if (li == 16)
            li = 25;
        return cased_letter(li);
    endfunction

    function automatic logic [CHAR_W-1:0] key_noise_byte();
        logic [CHAR_W-1:0] b;
        int                li;
        do
        begin
            b  = rand_byte();
            li = letter_of(b);
        end
        while (li >= HELD_FIRST && li <= HELD_LAST);
        return b;
    endfunction

    function automatic logic [CHAR_W-1:0] text_byte();
        if ($urandom_range(0, 1) == 1)
            return cased_letter($urandom_range(0, ALPHABET_SIZE - 1));
        return rand_byte();
    endfunction

    function automatic logic [CODE_W-1:0] probe_code();
        if (codes_issued > 0 && $urandom_range(0, 1) == 1)
            return CODE_W'($urandom_range(0, codes_issued - 1));
        return CODE_W'($urandom_range(0, BCC_MAX_CODES - 1));
    endfunction

    task automatic send_command(action_t act, logic [CHAR_W-1:0] ch, logic [CODE_W-1:0] code,
            logic [RAND_W-1:0] rnd);
        int gap;
        action       <= act;
        char_in      <= ch;
        code_in      <= code;
        random_value <= rnd;
        start        <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        outcomes_due.push_back(cipher_outcome(act, ch, code, rnd));
        items_sent++;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(action_t act, logic [CHAR_W-1:0] ch);
        send_command(act, ch, rand_code(), rand_value());
    endtask

    task automatic wait_outcomes_drained();
        start <= 1'b0;
        while (outcomes_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic maybe_flip_gaps();
        if ($urandom_range(0, 47) == 0)
            no_gap = !no_gap;
    endtask

    task automatic test_empty_tables();
        send_command(ACT_ENCODE, CHAR_LOWER_A, rand_code(), '0);
        send_random(ACT_ENCODE, 8'h00);
        send_command(ACT_DECODE, rand_byte(), '0, rand_value());
        send_command(ACT_DECODE, rand_byte(), '1, rand_value());
        wait_outcomes_drained();
    endtask

    task automatic test_letter_bounds();
        logic [CHAR_W-1:0] probe_chars [12] = '{8'h00, 8'h40, 8'h41, 8'h5a, 8'h5b, 8'h60,
                                                8'h61, 8'h7a, 8'h7b, 8'h7f, 8'h80, 8'hff};
        foreach (probe_chars[i])
            send_random(ACT_LOAD, probe_chars[i]);
        send_command(ACT_ENCODE, CHAR_UPPER_Z, rand_code(), '1);
        send_command(ACT_ENCODE, CHAR_LOWER_A, rand_code(), '0);
        send_command(ACT_ENCODE, CHAR_UPPER_A, rand_code(), 15'd1);
        send_random(ACT_ENCODE, 8'hff);
        send_random(ACT_ENCODE, CHAR_LOWER_A + 8'd12);
        send_command(ACT_DECODE, rand_byte(), 10'd0, rand_value());
        send_command(ACT_DECODE, rand_byte(), 10'd3, rand_value());
        send_command(ACT_DECODE, rand_byte(), 10'd4, rand_value());
        wait_outcomes_drained();
    endtask

    task automatic test_key_traffic();
        int pick;
        while (codes_issued < BCC_MAX_CODES - 24)
        begin
            maybe_flip_gaps();
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_random(ACT_LOAD, key_letter_byte());
            else if (pick < 75)
                send_random(ACT_LOAD, key_noise_byte());
            else if (pick < 90)
                send_random(ACT_ENCODE, text_byte());
            else
                send_command(ACT_DECODE, rand_byte(), probe_code(), rand_value());
        end
        wait_outcomes_drained();
    endtask

    task automatic test_close_overflow();
        while (codes_issued < BCC_MAX_CODES - 6)
            send_random(ACT_LOAD, key_letter_byte());
        // room for q..v only, w..y stay without codes
        send_random(ACT_CLOSE, rand_byte());
        for (int c = BCC_MAX_CODES - 6; c < BCC_MAX_CODES; c++)
            send_command(ACT_DECODE, rand_byte(), CODE_W'(c), rand_value());
        send_random(ACT_ENCODE, cased_letter(HELD_FIRST));
        send_random(ACT_ENCODE, cased_letter(HELD_FIRST + 5));
        send_random(ACT_ENCODE, cased_letter(HELD_FIRST + 6));
        send_random(ACT_LOAD, cased_letter(1));
        send_random(ACT_LOAD, 8'h2e);
        send_random(ACT_CLOSE, rand_byte());
        wait_outcomes_drained();
    endtask

    task automatic test_full_store_traffic();
        int target;
        int pick;
        target = items_sent + 150;
        if (target < RANDOM_ITEMS)
            target = RANDOM_ITEMS;
        while (items_sent < target)
        begin
            maybe_flip_gaps();
            pick = $urandom_range(0, 99);
            if (pick < 30)
                send_random(ACT_LOAD, text_byte());
            else if (pick < 35)
                send_random(ACT_CLOSE, rand_byte());
            else if (pick < 70)
                send_random(ACT_ENCODE, text_byte());
            else
                send_command(ACT_DECODE, rand_byte(), rand_code(), rand_value());
        end
        wait_outcomes_drained();
    endtask

    always @(posedge clk)
    begin : check_outcomes
        cipher_outcome_t due;
        if (rst_n && done)
        begin
            if (outcomes_due.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected transfer: status %0d code %0d letter %02h",
                             status, code_out, letter_out);
                mismatches++;
            end
            else
            begin
                due = outcomes_due.pop_front();
                if (status !== due.st || code_out !== due.code || letter_out !== due.letter)
                begin
                    if (mismatches < 10)
                        $display("mismatch: status %0d/%0d code %0d/%0d letter %02h/%02h",
                                 due.st, status, due.code, code_out, due.letter, letter_out);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_tables();
        test_letter_bounds();
        test_key_traffic();
        test_close_overflow();
        test_full_store_traffic();
        if (mismatches == 0 && outcomes_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
rtl/bcc_pkg.sv
rtl/bcc_front.sv
rtl/bcc_fifo.sv
rtl/bcc_mod.sv
rtl/bcc_back.sv
rtl/book_cipher_codec.sv
rtl/bcc_checker.sv
bench/testbench.sv
